// File: design/cfr_pkg.sv
// Shared types and codes for the circular FIFO with reverse.
// No dependencies; the interfaces and the top level take it in.
`default_nettype none

package cfr_pkg;

    // Built depth of the word store; the 5-bit occupancy and capacity fields bound it
    localparam int DEPTH      = 16;
    localparam int WORD_W     = 32;
    localparam int OCC_W      = 5;
    localparam int RESET_CAP  = 16;

    typedef logic [1:0]               func_t;
    typedef logic [1:0]               status_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [OCC_W-1:0]         occ_t;

    // Operation codes
    localparam func_t FUNC_ENQ  = 2'd0;
    localparam func_t FUNC_DEQ  = 2'd1;
    localparam func_t FUNC_PEEK = 2'd2;
    localparam func_t FUNC_REV  = 2'd3;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: design/cfr_if.sv
// Request and response channels of the circular FIFO with reverse.
// Depends on cfr_pkg for the payload types.
`default_nettype none

interface cfr_req_if;
    import cfr_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    word_t data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface cfr_rsp_if;
    import cfr_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    word_t   data_out;
    occ_t    occupancy;

    modport source (output valid, output status, output data_out, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input data_out, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// File: design/cfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/circular_fifo_with_reverse.sv
// Circular FIFO of signed 32-bit words with a run-time capacity (1..DEPTH, clamped)
// and an order-reversal command. One request beat is taken at a time; each gives one
// response beat. Enqueue and any refused command answer straight from the idle state;
// dequeue and peek pass a read-wait state (the word store read is registered); reverse
// gathers the n stored words from the ring into a scratch RAM one a cycle, then writes
// them back in reverse from slot 0 one a cycle, each pass limited by the single read
// and write port of the RAMs. A response waiting in the output register does not stop
// the next request beat from being taken. Depends on cfr_pkg, cfr_if, cfr_ram.
`default_nettype none

module circular_fifo_with_reverse (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire cfr_pkg::occ_t cfg_wr_data,
    cfr_req_if.sink            req,
    cfr_rsp_if.source          rsp
);
    import cfr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (AW > OCC_W) ? AW : OCC_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RDWAIT  = 3'd1;
    localparam logic [2:0] S_GATHER  = 3'd2;
    localparam logic [2:0] S_SCATTER = 3'd3;
    localparam logic [2:0] S_HOLD    = 3'd4;

    logic [2:0]    state_reg, state_next;
    occ_t          cap_reg;
    occ_t          live_cap;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    occ_t          count_reg, count_next;
    logic [AW-1:0] src_reg, src_next;
    occ_t          cnt_reg, cnt_next;
    logic          lag_reg, lag_next;
    logic [AW-1:0] lidx_reg, lidx_next;

    logic          rsp_valid_reg, rsp_valid_next;
    status_t       rsp_status_reg, rsp_status_next;
    word_t         rsp_data_reg, rsp_data_next;
    occ_t          rsp_occ_reg, rsp_occ_next;
    status_t       hold_status_reg, hold_status_next;
    word_t         hold_data_reg, hold_data_next;
    occ_t          hold_occ_reg, hold_occ_next;

    logic          fin;
    status_t       fin_status;
    word_t         fin_data;
    occ_t          fin_occ;
    logic          slot_free;

    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    word_t         st_wdata, st_rdata;
    logic          sc_we, sc_re;
    logic [AW-1:0] sc_waddr, sc_raddr;
    word_t         sc_wdata, sc_rdata;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input occ_t cap);
        logic [XW:0] nxt;
        nxt = (XW+1)'(idx) + (XW+1)'(1);
        return (nxt >= (XW+1)'(cap)) ? '0 : AW'(nxt);
    endfunction

    cfr_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    cfr_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_scratch (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .re    (sc_re),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

    // Clamp the capacity register into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            live_cap = OCC_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            live_cap = OCC_W'(DEPTH);
        end
        else
        begin
            live_cap = cap_reg;
        end
    end

    assign slot_free     = !rsp_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.data_out  = rsp_data_reg;
    assign rsp.occupancy = rsp_occ_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        src_next         = src_reg;
        cnt_next         = cnt_reg;
        lag_next         = lag_reg;
        lidx_next        = lidx_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_data_next    = rsp_data_reg;
        rsp_occ_next     = rsp_occ_reg;
        hold_status_next = hold_status_reg;
        hold_data_next   = hold_data_reg;
        hold_occ_next    = hold_occ_reg;
        fin              = 1'b0;
        fin_status       = ST_OK;
        fin_data         = '0;
        fin_occ          = count_reg;
        st_we            = 1'b0;
        st_waddr         = tail_reg;
        st_wdata         = req.data_in;
        st_re            = 1'b0;
        st_raddr         = head_reg;
        sc_we            = 1'b0;
        sc_waddr         = lidx_reg;
        sc_wdata         = st_rdata;
        sc_re            = 1'b0;
        sc_raddr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FUNC_ENQ)
                    begin
                        fin = 1'b1;
                        if (count_reg >= live_cap)
                        begin
                            fin_status = ST_FULL;
                        end
                        else
                        begin
                            st_we      = 1'b1;
                            tail_next  = adv(tail_reg, live_cap);
                            count_next = count_reg + OCC_W'(1);
                            fin_occ    = count_reg + OCC_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                        fin_data   = '1;
                    end
                    else if (req.func == FUNC_REV)
                    begin
                        src_next   = head_reg;
                        cnt_next   = '0;
                        lag_next   = 1'b0;
                        state_next = S_GATHER;
                    end
                    else
                    begin
                        st_re      = 1'b1;
                        state_next = S_RDWAIT;
                        if (req.func == FUNC_DEQ)
                        begin
                            head_next  = adv(head_reg, live_cap);
                            count_next = count_reg - OCC_W'(1);
                        end
                    end
                end
            end

            S_RDWAIT:
            begin
                fin      = 1'b1;
                fin_data = st_rdata;
            end

            // Copy the ring, oldest first, into scratch slots 0..n-1
            S_GATHER:
            begin
                sc_we = lag_reg;
                if (cnt_reg < count_reg)
                begin
                    st_re     = 1'b1;
                    st_raddr  = src_reg;
                    src_next  = adv(src_reg, live_cap);
                    cnt_next  = cnt_reg + OCC_W'(1);
                    lag_next  = 1'b1;
                    lidx_next = AW'(cnt_reg);
                end
                else
                begin
                    cnt_next   = '0;
                    lag_next   = 1'b0;
                    state_next = S_SCATTER;
                end
            end

            // Write scratch back, newest first, into store slots 0..n-1
            S_SCATTER:
            begin
                st_we    = lag_reg;
                st_waddr = lidx_reg;
                st_wdata = sc_rdata;
                if (cnt_reg < count_reg)
                begin
                    sc_re     = 1'b1;
                    sc_raddr  = AW'(count_reg - OCC_W'(1) - cnt_reg);
                    cnt_next  = cnt_reg + OCC_W'(1);
                    lag_next  = 1'b1;
                    lidx_next = AW'(cnt_reg);
                end
                else
                begin
                    lag_next  = 1'b0;
                    head_next = '0;
                    tail_next = (count_reg < live_cap) ? AW'(count_reg) : '0;
                    fin       = 1'b1;
                end
            end

            S_HOLD:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = hold_status_reg;
                    rsp_data_next   = hold_data_reg;
                    rsp_occ_next    = hold_occ_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Send the beat straight out if the output register frees up, else park it
        if (fin)
        begin
            if (slot_free)
            begin
                rsp_valid_next  = 1'b1;
                rsp_status_next = fin_status;
                rsp_data_next   = fin_data;
                rsp_occ_next    = fin_occ;
                state_next      = S_IDLE;
            end
            else
            begin
                hold_status_next = fin_status;
                hold_data_next   = fin_data;
                hold_occ_next    = fin_occ;
                state_next       = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= OCC_W'(RESET_CAP);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            lag_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            lag_reg       <= lag_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg         <= src_next;
        lidx_reg        <= lidx_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_data_reg    <= rsp_data_next;
        rsp_occ_reg     <= rsp_occ_next;
        hold_status_reg <= hold_status_next;
        hold_data_reg   <= hold_data_next;
        hold_occ_reg    <= hold_occ_next;
    end

    // An accepted enqueue with room grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.func == FUNC_ENQ && count_reg < live_cap)
        |=> (count_reg == $past(count_reg) + OCC_W'(1)))
        else $error("enqueue did not grow the count");

    // The count only moves when a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("count changed while busy");

    // A finished reverse leaves the head at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCATTER && cnt_reg == count_reg) |=> (head_reg == '0))
        else $error("reverse left head off slot zero");

    // A response is parked only behind one still waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> rsp_valid_reg)
        else $error("response parked with output register empty");

endmodule

`default_nettype wire
